>>> design/bgtf_pkg.sv
// Shared types, microcode and curve constants for the battery gauge filter.
`default_nettype none
package bgtf_pkg;

  // datapath operations
  localparam logic [3:0] OP_NOP      = 4'd0;
  localparam logic [3:0] OP_ACCUM    = 4'd1;
  localparam logic [3:0] OP_LOAD_SUM = 4'd2;
  localparam logic [3:0] OP_SUB      = 4'd3;
  localparam logic [3:0] OP_DIV_MEAN = 4'd4;
  localparam logic [3:0] OP_DIV_STEP = 4'd5;
  localparam logic [3:0] OP_BLEND    = 4'd6;
  localparam logic [3:0] OP_ADC      = 4'd7;
  localparam logic [3:0] OP_MUL      = 4'd8;
  localparam logic [3:0] OP_WINDOW   = 4'd9;
  localparam logic [3:0] OP_SEG_INIT = 4'd10;
  localparam logic [3:0] OP_PCT_FULL = 4'd11;
  localparam logic [3:0] OP_SEG_NEXT = 4'd12;
  localparam logic [3:0] OP_DIV_PCT  = 4'd13;
  localparam logic [3:0] OP_PCT_ADD  = 4'd14;
  localparam logic [3:0] OP_LOAD_OUT = 4'd15;

  // subtrahend select for OP_SUB
  localparam logic [1:0] SEL_L0 = 2'd0;
  localparam logic [1:0] SEL_L1 = 2'd1;
  localparam logic [1:0] SEL_H0 = 2'd2;
  localparam logic [1:0] SEL_H1 = 2'd3;

  // jump conditions
  localparam logic [3:0] C_NEVER       = 4'd0;
  localparam logic [3:0] C_ALWAYS      = 4'd1;
  localparam logic [3:0] C_NO_START    = 4'd2;
  localparam logic [3:0] C_CNT_NZ      = 4'd3;
  localparam logic [3:0] C_NOT_OK      = 4'd4;
  localparam logic [3:0] C_MV_LE_FIRST = 4'd5;
  localparam logic [3:0] C_MV_GE_LAST  = 4'd6;
  localparam logic [3:0] C_MV_GT_K     = 4'd7;
  localparam logic [3:0] C_OUT_BUSY    = 4'd8;

  // program steps
  localparam logic [4:0] ST_IDLE     = 5'd0;
  localparam logic [4:0] ST_LOAD     = 5'd1;
  localparam logic [4:0] ST_SUB_L0   = 5'd2;
  localparam logic [4:0] ST_SUB_L1   = 5'd3;
  localparam logic [4:0] ST_SUB_H0   = 5'd4;
  localparam logic [4:0] ST_SUB_H1   = 5'd5;
  localparam logic [4:0] ST_DIVM     = 5'd6;
  localparam logic [4:0] ST_BLEND    = 5'd7;
  localparam logic [4:0] ST_ADC      = 5'd8;
  localparam logic [4:0] ST_MUL      = 5'd9;
  localparam logic [4:0] ST_WINDOW   = 5'd10;
  localparam logic [4:0] ST_SEG_INIT = 5'd11;
  localparam logic [4:0] ST_FULL     = 5'd12;
  localparam logic [4:0] ST_SEG      = 5'd13;
  localparam logic [4:0] ST_DIVP     = 5'd14;
  localparam logic [4:0] ST_DIVP_LP  = 5'd15;
  localparam logic [4:0] ST_PCT      = 5'd16;
  localparam logic [4:0] ST_OUT      = 5'd17;
  localparam logic [4:0] ST_DONE     = 5'd18;

  // configuration register indexes
  localparam logic [1:0] REG_GAIN    = 2'd0;
  localparam logic [1:0] REG_MIN     = 2'd1;
  localparam logic [1:0] REG_MAX     = 2'd2;

  localparam logic [15:0] GAIN_RST    = 16'd8192;
  localparam logic [15:0] MIN_RST     = 16'd3000;
  localparam logic [15:0] MAX_RST     = 16'd4500;

  localparam int CURVE_POINTS = 11;
  localparam logic [3:0] CURVE_LAST = 4'd10;
  localparam logic [15:0] CURVE_MV [CURVE_POINTS] = '{
    16'd3500, 16'd3550, 16'd3650, 16'd3700, 16'd3740, 16'd3790,
    16'd3850, 16'd3920, 16'd4000, 16'd4100, 16'd4200
  };
  localparam logic [6:0] CURVE_PCT [CURVE_POINTS] = '{
    7'd0, 7'd10, 7'd20, 7'd30, 7'd40, 7'd50, 7'd60, 7'd70, 7'd80, 7'd90, 7'd100
  };

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] sel;
    logic [3:0] cond;
    logic [4:0] target;
  } ctrl_t;

  // control store: jump to target when cond holds, else fall through
  function automatic ctrl_t ucode(input logic [4:0] step);
    ctrl_t cw;
    case (step)
      ST_IDLE:     cw = '{OP_ACCUM,    SEL_L0, C_NO_START,    ST_IDLE};
      ST_LOAD:     cw = '{OP_LOAD_SUM, SEL_L0, C_NEVER,       ST_IDLE};
      ST_SUB_L0:   cw = '{OP_SUB,      SEL_L0, C_NEVER,       ST_IDLE};
      ST_SUB_L1:   cw = '{OP_SUB,      SEL_L1, C_NEVER,       ST_IDLE};
      ST_SUB_H0:   cw = '{OP_SUB,      SEL_H0, C_NEVER,       ST_IDLE};
      ST_SUB_H1:   cw = '{OP_SUB,      SEL_H1, C_NEVER,       ST_IDLE};
      ST_DIVM:     cw = '{OP_DIV_MEAN, SEL_L0, C_NEVER,       ST_IDLE};
      ST_BLEND:    cw = '{OP_BLEND,    SEL_L0, C_NEVER,       ST_IDLE};
      ST_ADC:      cw = '{OP_ADC,      SEL_L0, C_NEVER,       ST_IDLE};
      ST_MUL:      cw = '{OP_MUL,      SEL_L0, C_NEVER,       ST_IDLE};
      ST_WINDOW:   cw = '{OP_WINDOW,   SEL_L0, C_NOT_OK,      ST_OUT};
      ST_SEG_INIT: cw = '{OP_SEG_INIT, SEL_L0, C_MV_LE_FIRST, ST_OUT};
      ST_FULL:     cw = '{OP_PCT_FULL, SEL_L0, C_MV_GE_LAST,  ST_OUT};
      ST_SEG:      cw = '{OP_SEG_NEXT, SEL_L0, C_MV_GT_K,     ST_SEG};
      ST_DIVP:     cw = '{OP_DIV_PCT,  SEL_L0, C_NEVER,       ST_IDLE};
      ST_DIVP_LP:  cw = '{OP_DIV_STEP, SEL_L0, C_CNT_NZ,      ST_DIVP_LP};
      ST_PCT:      cw = '{OP_PCT_ADD,  SEL_L0, C_NEVER,       ST_IDLE};
      ST_OUT:      cw = '{OP_LOAD_OUT, SEL_L0, C_OUT_BUSY,    ST_OUT};
      ST_DONE:     cw = '{OP_NOP,      SEL_L0, C_ALWAYS,      ST_IDLE};
      default:     cw = '{OP_NOP,      SEL_L0, C_ALWAYS,      ST_IDLE};
    endcase
    return cw;
  endfunction

endpackage
`default_nettype wire

>>> design/battery_gauge_trimmed_filter.sv
// Battery gauge: trimmed-mean burst filter, averaging, scaling and percent lookup.
//
//  channel | signals                                   | dir | notes
//  in      | in_valid in_ready sample_mv reseed        | in  | one sample per item
//  out     | out_valid out_ready filtered_adc_mv       | out | one item per burst
//          | pack_mv in_window charge_percent          |     |
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data    | in  | ready out of reset
//
// A sample that does not end a burst is taken while the program stays in idle;
// the last sample of a burst starts the microprogram. The mean is a single
// reciprocal multiply step; the work goes to up to ten curve steps and the
// SUM_W-step one-bit-per-cycle divider of the interpolation, with SUM_W = 12 +
// clog2(SAMPLES_PER_BURST). Input is held off until the program is back in idle;
// it waits at the output load only while a previous result has not been taken.
// Synchronous reset; no handshake is ready in reset.
`default_nettype none
module battery_gauge_trimmed_filter #(
  parameter int SAMPLES_PER_BURST = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [11:0] sample_mv,
  input  wire logic        reseed,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [11:0]      filtered_adc_mv,
  output logic [15:0]      pack_mv,
  output logic             in_window,
  output logic [6:0]       charge_percent,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int SUM_W = 12 + $clog2(SAMPLES_PER_BURST);
  localparam int CNT_W = $clog2(SAMPLES_PER_BURST);
  localparam int DCNT_W = $clog2(SUM_W);
  localparam int KEPT = SAMPLES_PER_BURST - 4;
  // ceil(2^DIV_S / KEPT) gives an exact floor division for any SUM_W-bit dividend
  localparam int DIV_L   = $clog2(KEPT);
  localparam int DIV_S   = SUM_W + DIV_L;
  localparam int RECIP_W = SUM_W + 2;
  localparam int RECIP   = ((1 << DIV_S) + KEPT - 1) / KEPT;

  logic [15:0] gain, vmin, vmax;

  logic [4:0]        step;
  logic [4:0]        step_next;
  bgtf_pkg::ctrl_t   cw;

  logic [CNT_W-1:0]  count;
  logic [SUM_W-1:0]  sum;
  logic [11:0]       low0, low1, high0, high1;
  logic              pending, seeded;
  logic [19:0]       avg;

  logic [SUM_W-1:0]  acc;    // dividend in, quotient out
  logic [6:0]        rem;
  logic [6:0]        divisor;
  logic [DCNT_W-1:0] dcnt;

  logic [11:0]       adc;
  logic [15:0]       mv;
  logic              ok;
  logic [3:0]        k;
  logic [6:0]        pct;

  logic              accept, last, cond_hit, out_busy, win_ok;
  logic [11:0]       subtrahend;
  logic [7:0]        rem_sh;
  logic              fits;
  logic [2*SUM_W+1:0] quot_prod;
  logic [21:0]       blend;
  logic [12:0]       adc_wide;
  logic [28:0]       prod;
  logic [16:0]       mv_wide;
  logic [3:0]        km1;
  logic [15:0]       span_full, into_full;
  logic [10:0]       pct_num;

  assign cw        = bgtf_pkg::ucode(step);
  assign in_ready  = (cw.op == bgtf_pkg::OP_ACCUM) && !rst;
  assign cfg_ready = !rst;
  assign accept    = in_valid && in_ready;
  assign last      = (count == CNT_W'(SAMPLES_PER_BURST - 1));
  assign out_busy  = out_valid && !out_ready;
  assign win_ok    = (mv >= vmin) && (mv <= vmax);

  always_comb begin
    case (cw.sel)
      bgtf_pkg::SEL_L0: subtrahend = low0;
      bgtf_pkg::SEL_L1: subtrahend = low1;
      bgtf_pkg::SEL_H0: subtrahend = high0;
      bgtf_pkg::SEL_H1: subtrahend = high1;
      default:          subtrahend = low0;
    endcase
  end

  assign rem_sh = {rem, acc[SUM_W-1]};
  assign fits   = (rem_sh >= {1'b0, divisor});

  assign quot_prod = {{(SUM_W+2){1'b0}}, acc} * {{SUM_W{1'b0}}, RECIP_W'(RECIP)};

  assign blend    = {1'b0, avg, 1'b0} + {2'b00, avg} + {2'b00, acc[11:0], 8'd0} + 22'd2;
  assign adc_wide = {1'b0, avg[19:8]} + {12'd0, avg[7]};
  assign prod     = {17'd0, adc} * {13'd0, gain} + 29'd2048;
  assign mv_wide  = prod[28:12];

  assign km1       = k - 4'd1;
  assign span_full = bgtf_pkg::CURVE_MV[k] - bgtf_pkg::CURVE_MV[km1];
  assign into_full = mv - bgtf_pkg::CURVE_MV[km1];
  assign pct_num   = {1'b0, into_full[6:0], 3'b000} + {3'b000, into_full[6:0], 1'b0}
                   + {5'd0, span_full[6:1]};

  always_comb begin
    case (cw.cond)
      bgtf_pkg::C_NEVER:       cond_hit = 1'b0;
      bgtf_pkg::C_ALWAYS:      cond_hit = 1'b1;
      bgtf_pkg::C_NO_START:    cond_hit = !(accept && last);
      bgtf_pkg::C_CNT_NZ:      cond_hit = (dcnt != '0);
      bgtf_pkg::C_NOT_OK:      cond_hit = !win_ok;
      bgtf_pkg::C_MV_LE_FIRST: cond_hit = (mv <= bgtf_pkg::CURVE_MV[0]);
      bgtf_pkg::C_MV_GE_LAST:  cond_hit = (mv >= bgtf_pkg::CURVE_MV[bgtf_pkg::CURVE_LAST]);
      bgtf_pkg::C_MV_GT_K:     cond_hit = (mv > bgtf_pkg::CURVE_MV[k]);
      bgtf_pkg::C_OUT_BUSY:    cond_hit = out_busy;
      default:                 cond_hit = 1'b0;
    endcase
    step_next = cond_hit ? cw.target : step + 5'd1;
  end

  // sequencer and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= bgtf_pkg::ST_IDLE;
      gain <= bgtf_pkg::GAIN_RST;
      vmin <= bgtf_pkg::MIN_RST;
      vmax <= bgtf_pkg::MAX_RST;
    end else begin
      step <= step_next;
      if (cfg_valid) begin
        case (cfg_index)
          bgtf_pkg::REG_GAIN: gain <= cfg_data;
          bgtf_pkg::REG_MIN:  vmin <= cfg_data;
          bgtf_pkg::REG_MAX:  vmax <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // burst state and filter
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      sum     <= '0;
      low0    <= 12'hFFF;
      low1    <= 12'hFFF;
      high0   <= 12'd0;
      high1   <= 12'd0;
      pending <= 1'b0;
      seeded  <= 1'b0;
      avg     <= 20'd0;
    end else begin
      case (cw.op)
        bgtf_pkg::OP_ACCUM: begin
          if (accept) begin
            count <= count + CNT_W'(1);
            sum   <= sum + SUM_W'(sample_mv);
            if (reseed) pending <= 1'b1;
            if (sample_mv < low0) begin
              low1 <= low0;
              low0 <= sample_mv;
            end else if (sample_mv < low1) begin
              low1 <= sample_mv;
            end
            if (sample_mv > high0) begin
              high1 <= high0;
              high0 <= sample_mv;
            end else if (sample_mv > high1) begin
              high1 <= sample_mv;
            end
          end
        end
        bgtf_pkg::OP_BLEND: begin
          if (pending || !seeded) avg <= {acc[11:0], 8'd0};
          else                    avg <= blend[21:2];
          seeded  <= 1'b1;
          count   <= '0;
          sum     <= '0;
          low0    <= 12'hFFF;
          low1    <= 12'hFFF;
          high0   <= 12'd0;
          high1   <= 12'd0;
          pending <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // working datapath
  always_ff @(posedge clk) begin
    case (cw.op)
      bgtf_pkg::OP_LOAD_SUM: acc <= sum + SUM_W'(KEPT / 2);
      bgtf_pkg::OP_SUB:      acc <= acc - SUM_W'(subtrahend);
      bgtf_pkg::OP_DIV_MEAN: acc <= {{(SUM_W-12){1'b0}}, quot_prod[DIV_S +: 12]};
      bgtf_pkg::OP_DIV_STEP: begin
        dcnt <= dcnt - DCNT_W'(1);
        if (fits) begin
          rem <= 7'(rem_sh - {1'b0, divisor});
          acc <= {acc[SUM_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh[6:0];
          acc <= {acc[SUM_W-2:0], 1'b0};
        end
      end
      bgtf_pkg::OP_ADC:  adc <= adc_wide[12] ? 12'hFFF : adc_wide[11:0];
      bgtf_pkg::OP_MUL:  mv  <= mv_wide[16] ? 16'hFFFF : mv_wide[15:0];
      bgtf_pkg::OP_WINDOW: begin
        ok  <= win_ok;
        pct <= 7'd0;
      end
      bgtf_pkg::OP_SEG_INIT: k <= 4'd1;
      bgtf_pkg::OP_PCT_FULL: pct <= bgtf_pkg::CURVE_PCT[bgtf_pkg::CURVE_LAST];
      bgtf_pkg::OP_SEG_NEXT: begin
        if (mv > bgtf_pkg::CURVE_MV[k]) k <= k + 4'd1;
      end
      bgtf_pkg::OP_DIV_PCT: begin
        acc     <= {{(SUM_W-11){1'b0}}, pct_num};
        rem     <= 7'd0;
        divisor <= span_full[6:0];
        dcnt    <= DCNT_W'(SUM_W - 1);
      end
      bgtf_pkg::OP_PCT_ADD: pct <= bgtf_pkg::CURVE_PCT[km1] + acc[6:0];
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cw.op == bgtf_pkg::OP_LOAD_OUT && !out_busy) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.op == bgtf_pkg::OP_LOAD_OUT && !out_busy) begin
      filtered_adc_mv <= adc;
      pack_mv         <= mv;
      in_window       <= ok;
      charge_percent  <= pct;
    end
  end

endmodule
`default_nettype wire
